[sv/alfl_pkg.sv]
// shared types, codes and widths of the array linked list with free list
package alfl_pkg;

    // default slot count, the sentinel included
    localparam int NodeCountDef = 16;

    // fixed field widths
    localparam int ActionW = 2;
    localparam int KeyW    = 32;
    localparam int SlotW   = 4;
    localparam int StatusW = 2;

    // stream payload widths, tdata padded to whole bytes
    localparam int SDataW = ((KeyW + SlotW + 7) / 8) * 8;
    localparam int SUserW = ActionW;
    localparam int MDataW = ((StatusW + SlotW + 7) / 8) * 8;

    typedef logic signed [KeyW-1:0] key_t;

    // beat actions
    typedef enum logic [ActionW-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    // result status codes
    typedef enum logic [StatusW-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_BAD_SLOT  = 2'd3
    } status_t;

    // strobes from the sequencer to the link store
    typedef struct packed {
        logic rd_en;    // read all three arrays at the read address
        logic next_we;  // write next link
        logic prev_we;  // write previous link
        logic key_we;   // write key at the next-link write address
        logic alloc;    // slot at the next-link write address leaves the free list
    } store_cmd_t;

endpackage

[sv/array_linked_list_with_free_list.sv]
// top level: doubly linked list with sentinel and free list over link arrays
//
//  channel | direction | payload
//  --------+-----------+----------------------------------------------------------
//  s_      | in        | tuser: action; tdata: key_value, slot_index
//  m_      | out       | tdata: status, result_slot
//
// insert steps through link and head states, delete through unlink and free
// states, each then the finish state; a search compares one list node per read,
// up to NODE_COUNT, set by the single shared read port of the link and key arrays.
// a refused insert, a rejected delete or action, or a search of an empty list
// goes straight to S_FIN. no clearing pass after reset: a fill count supplies the
// initial free chain. one request at a time; a stalled result holds the sequencer.
module array_linked_list_with_free_list #(
    parameter int NODE_COUNT = alfl_pkg::NodeCountDef
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [alfl_pkg::SDataW-1:0] s_tdata,   // key_value[31:0], slot_index[35:32]
    input  logic [alfl_pkg::SUserW-1:0] s_tuser,   // action[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [alfl_pkg::MDataW-1:0] m_tdata    // status[1:0], result_slot[5:2]
);
    import alfl_pkg::*;

    localparam int LinkW = $clog2(NODE_COUNT);

    store_cmd_t       cmd;
    logic [LinkW-1:0] rd_addr;
    logic [LinkW-1:0] next_wa;
    logic [LinkW-1:0] next_wd;
    logic [LinkW-1:0] prev_wa;
    logic [LinkW-1:0] prev_wd;
    key_t             key_wd;
    logic [LinkW-1:0] next_rd;
    logic [LinkW-1:0] prev_rd;
    key_t             key_rd;

    key_t             s_key;
    logic [SlotW-1:0] s_slot;
    status_t          m_status;
    logic [SlotW-1:0] m_slot;

    // unpack the request beat
    assign s_key  = key_t'(s_tdata[KeyW-1:0]);
    assign s_slot = s_tdata[KeyW +: SlotW];

    // pack the result beat
    assign m_tdata = MDataW'({m_slot, m_status});

    alfl_ctrl #(
        .NODE_COUNT (NODE_COUNT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_action (s_tuser[ActionW-1:0]),
        .s_key    (s_key),
        .s_slot   (s_slot),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_status (m_status),
        .m_slot   (m_slot),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .next_wa  (next_wa),
        .next_wd  (next_wd),
        .prev_wa  (prev_wa),
        .prev_wd  (prev_wd),
        .key_wd   (key_wd),
        .next_rd  (next_rd),
        .prev_rd  (prev_rd),
        .key_rd   (key_rd)
    );

    alfl_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .next_wa (next_wa),
        .next_wd (next_wd),
        .prev_wa (prev_wa),
        .prev_wd (prev_wd),
        .key_wd  (key_wd),
        .next_rd (next_rd),
        .prev_rd (prev_rd),
        .key_rd  (key_rd)
    );

endmodule

[sv/alfl_store.sv]
// link and key memories with a fill count that stands in for the free-chain reset
module alfl_store #(
    parameter int NODE_COUNT = alfl_pkg::NodeCountDef,
    localparam int LinkW = $clog2(NODE_COUNT),
    localparam int FillW = $clog2(NODE_COUNT + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  alfl_pkg::store_cmd_t cmd,
    input  logic [LinkW-1:0]     rd_addr,
    input  logic [LinkW-1:0]     next_wa,
    input  logic [LinkW-1:0]     next_wd,
    input  logic [LinkW-1:0]     prev_wa,
    input  logic [LinkW-1:0]     prev_wd,
    input  alfl_pkg::key_t       key_wd,
    output logic [LinkW-1:0]     next_rd,
    output logic [LinkW-1:0]     prev_rd,
    output alfl_pkg::key_t       key_rd
);
    import alfl_pkg::*;

    localparam logic [LinkW-1:0] LastSlot = LinkW'(NODE_COUNT - 1);

    logic [LinkW-1:0] next_mem [NODE_COUNT];
    logic [LinkW-1:0] prev_mem [NODE_COUNT];
    key_t             key_mem  [NODE_COUNT];

    logic [LinkW-1:0] next_q_reg;
    logic [LinkW-1:0] prev_q_reg;
    key_t             key_q_reg;
    logic [LinkW-1:0] raddr_reg;
    logic             fresh_reg;
    logic [FillW-1:0] fill_reg;

    // memory writes
    always_ff @(posedge aclk) begin
        if (cmd.next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (cmd.prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (cmd.key_we) begin
            key_mem[next_wa] <= key_wd;
        end
    end

    // registered reads at one shared address
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            next_q_reg <= next_mem[rd_addr];
            prev_q_reg <= prev_mem[rd_addr];
            key_q_reg  <= key_mem[rd_addr];
            raddr_reg  <= rd_addr;
        end
    end

    // slots at or above the fill count were never written and still hold the reset chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= FillW'(1);
            fresh_reg <= 1'b0;
        end else begin
            if (cmd.rd_en) begin
                fresh_reg <= (FillW'(rd_addr) >= fill_reg);
            end
            if (cmd.alloc && (FillW'(next_wa) == fill_reg)) begin
                fill_reg <= fill_reg + FillW'(1);
            end
        end
    end

    // reset chain runs slot to slot plus one, the last slot ends it
    always_comb begin
        if (fresh_reg) begin
            next_rd = (raddr_reg == LastSlot) ? '0 : raddr_reg + LinkW'(1);
        end else begin
            next_rd = next_q_reg;
        end
    end

    assign prev_rd = prev_q_reg;
    assign key_rd  = key_q_reg;

endmodule

[sv/alfl_ctrl.sv]
// sequencer: list head, free head, in-use marks, key compare and result register
module alfl_ctrl #(
    parameter int NODE_COUNT = alfl_pkg::NodeCountDef,
    localparam int LinkW  = $clog2(NODE_COUNT),
    localparam int UseCnt = (NODE_COUNT < 16) ? NODE_COUNT : 16,
    localparam int UseW   = $clog2(UseCnt)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request side
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [alfl_pkg::ActionW-1:0]       s_action,
    input  alfl_pkg::key_t                     s_key,
    input  logic [alfl_pkg::SlotW-1:0]         s_slot,
    // result side
    output logic                               m_valid,
    input  logic                               m_ready,
    output alfl_pkg::status_t                  m_status,
    output logic [alfl_pkg::SlotW-1:0]         m_slot,
    // link store
    output alfl_pkg::store_cmd_t               cmd,
    output logic [LinkW-1:0]                   rd_addr,
    output logic [LinkW-1:0]                   next_wa,
    output logic [LinkW-1:0]                   next_wd,
    output logic [LinkW-1:0]                   prev_wa,
    output logic [LinkW-1:0]                   prev_wd,
    output alfl_pkg::key_t                     key_wd,
    input  logic [LinkW-1:0]                   next_rd,
    input  logic [LinkW-1:0]                   prev_rd,
    input  alfl_pkg::key_t                     key_rd
);
    import alfl_pkg::*;

    localparam logic [LinkW-1:0] LastStep = LinkW'(NODE_COUNT - 1);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_INS_LINK   = 7'b0000010,
        S_INS_HEAD   = 7'b0000100,
        S_SRCH       = 7'b0001000,
        S_DEL_UNLINK = 7'b0010000,
        S_DEL_FREE   = 7'b0100000,
        S_FIN        = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [LinkW-1:0] cur_reg, cur_next;
    key_t             key_reg, key_next;
    logic [LinkW-1:0] steps_reg, steps_next;
    logic [LinkW-1:0] head_reg, head_next;
    logic [LinkW-1:0] free_head_reg, free_head_next;
    logic [UseCnt-1:0] in_use_reg, in_use_next;
    status_t          res_status_reg, res_status_next;
    logic [SlotW-1:0] res_slot_reg, res_slot_next;
    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg, m_status_next;
    logic [SlotW-1:0] m_slot_reg, m_slot_next;

    logic             slot_ok;
    logic             key_hit;

    // delete target must be a live slot other than the sentinel
    assign slot_ok = (s_slot != '0) && (32'(s_slot) < NODE_COUNT)
                     && in_use_reg[UseW'(s_slot)];

    // the shared key comparator
    assign key_hit = (key_rd == key_reg);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        key_next        = key_reg;
        steps_next      = steps_reg;
        head_next       = head_reg;
        free_head_next  = free_head_reg;
        in_use_next     = in_use_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        cmd             = '0;
        rd_addr         = cur_reg;
        next_wa         = cur_reg;
        next_wd         = head_reg;
        prev_wa         = cur_reg;
        prev_wd         = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next      = s_key;
                    res_slot_next = '0;
                    case (action_t'(s_action))
                        ACT_INSERT: begin
                            if (free_head_reg == '0) begin
                                res_status_next = STAT_FULL;
                                state_next      = S_FIN;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                rd_addr    = free_head_reg;
                                cur_next   = free_head_reg;
                                state_next = S_INS_LINK;
                            end
                        end
                        ACT_SEARCH: begin
                            if (head_reg == '0) begin
                                res_status_next = STAT_NOT_FOUND;
                                state_next      = S_FIN;
                            end else begin
                                cmd.rd_en  = 1'b1;
                                rd_addr    = head_reg;
                                cur_next   = head_reg;
                                steps_next = '0;
                                state_next = S_SRCH;
                            end
                        end
                        ACT_DELETE: begin
                            if (slot_ok) begin
                                cmd.rd_en  = 1'b1;
                                rd_addr    = LinkW'(s_slot);
                                cur_next   = LinkW'(s_slot);
                                state_next = S_DEL_UNLINK;
                            end else begin
                                res_status_next = STAT_BAD_SLOT;
                                state_next      = S_FIN;
                            end
                        end
                        default: begin
                            res_status_next = STAT_BAD_SLOT;
                            state_next      = S_FIN;
                        end
                    endcase
                end
            end

            // pop the free head, store the key, point the new node at the old first
            S_INS_LINK: begin
                free_head_next = next_rd;
                cmd.next_we    = 1'b1;
                cmd.key_we     = 1'b1;
                cmd.prev_we    = 1'b1;
                cmd.alloc      = 1'b1;
                next_wa        = cur_reg;
                next_wd        = head_reg;
                prev_wa        = cur_reg;
                prev_wd        = '0;
                state_next     = S_INS_HEAD;
            end

            // old first points back at the new node, which becomes the head
            S_INS_HEAD: begin
                cmd.prev_we = 1'b1;
                prev_wa     = head_reg;
                prev_wd     = cur_reg;
                head_next   = cur_reg;
                if (32'(cur_reg) < UseCnt) begin
                    in_use_next[UseW'(cur_reg)] = 1'b1;
                end
                res_status_next = STAT_OK;
                res_slot_next   = SlotW'(cur_reg);
                state_next      = S_FIN;
            end

            // one node per cycle: compare, then read the successor
            S_SRCH: begin
                if (key_hit) begin
                    res_status_next = STAT_OK;
                    res_slot_next   = SlotW'(cur_reg);
                    state_next      = S_FIN;
                end else if ((next_rd == '0) || (steps_reg == LastStep)) begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_FIN;
                end else begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = next_rd;
                    cur_next   = next_rd;
                    steps_next = steps_reg + LinkW'(1);
                end
            end

            // bridge the neighbors around the slot
            S_DEL_UNLINK: begin
                cmd.prev_we = 1'b1;
                prev_wa     = next_rd;
                prev_wd     = prev_rd;
                if (prev_rd == '0) begin
                    head_next = next_rd;
                end else begin
                    cmd.next_we = 1'b1;
                    next_wa     = prev_rd;
                    next_wd     = next_rd;
                end
                state_next = S_DEL_FREE;
            end

            // push the slot onto the free list
            S_DEL_FREE: begin
                cmd.next_we    = 1'b1;
                next_wa        = cur_reg;
                next_wd        = free_head_reg;
                free_head_next = cur_reg;
                in_use_next[UseW'(cur_reg)] = 1'b0;
                res_status_next = STAT_OK;
                res_slot_next   = '0;
                state_next      = S_FIN;
            end

            // hand the result to the output register once it is free
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            free_head_reg <= LinkW'(1);
            in_use_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_head_reg <= free_head_next;
            in_use_reg    <= in_use_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        key_reg        <= key_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign key_wd   = key_reg;
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

[tb/sv/array_linked_list_with_free_list_checker.sv]
// checker: watches both channels, predicts list replies and compares them
module array_linked_list_with_free_list_checker #(
    parameter int NODE_COUNT = alfl_pkg::NodeCountDef
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [alfl_pkg::SDataW-1:0] s_tdata,   // key_value[31:0], slot_index[35:32]
    input  logic [alfl_pkg::SUserW-1:0] s_tuser,   // action[1:0]
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [alfl_pkg::MDataW-1:0] m_tdata,   // status[1:0], result_slot[5:2]
    output int                          error_count,
    output int                          pending_count,
    output int                          reply_count,
    output int                          full_count,
    output int                          found_count,
    output int                          missing_count,
    output int                          bad_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import alfl_pkg::*;

    typedef logic [SlotW-1:0] slot_t;

    typedef struct {
        status_t status;
        slot_t   slot;
    } list_reply_t;

    // shadow copy of the link arrays and free list
    slot_t next_link [NODE_COUNT];
    slot_t prev_link [NODE_COUNT];
    key_t  key_store [NODE_COUNT];
    logic  slot_used [NODE_COUNT];
    slot_t free_head;

    list_reply_t expected_replies[$];
    int mismatches;
    int replies_seen;
    int tally[4];

    function automatic void clear_list();
        for (int i = 0; i < NODE_COUNT; i++) begin
            next_link[i] = (i + 1 < NODE_COUNT && i != 0) ? slot_t'(i + 1) : '0;
            prev_link[i] = '0;
            key_store[i] = '0;
            slot_used[i] = 1'b0;
        end
        free_head = slot_t'(1);
    endfunction

    // apply one request to the shadow list and return the reply it gives
    function automatic list_reply_t apply_request(logic [ActionW-1:0] act, key_t key,
                                                  slot_t slot);
        list_reply_t r;
        slot_t x;
        slot_t first;
        slot_t nx;
        slot_t pv;
        r.status = STAT_BAD_SLOT;
        r.slot   = '0;
        case (act)
            ACT_INSERT: begin
                x = free_head;
                if (x == 0) begin
                    r.status = STAT_FULL;
                end else begin
                    free_head    = next_link[x];
                    key_store[x] = key;
                    first        = next_link[0];
                    next_link[x] = first;
                    prev_link[x] = '0;
                    prev_link[first] = x;
                    next_link[0] = x;
                    slot_used[x] = 1'b1;
                    r.status     = STAT_OK;
                    r.slot       = x;
                end
            end
            ACT_SEARCH: begin
                // walk from the head, bounded to one pass over all slots
                r.status = STAT_NOT_FOUND;
                x = next_link[0];
                for (int steps = 0; steps < NODE_COUNT && x != 0; steps++) begin
                    if (key_store[x] == key) begin
                        r.status = STAT_OK;
                        r.slot   = x;
                        break;
                    end
                    x = next_link[x];
                end
            end
            ACT_DELETE: begin
                if (slot != 0 && int'(slot) < NODE_COUNT && slot_used[slot]) begin
                    nx = next_link[slot];
                    pv = prev_link[slot];
                    prev_link[nx]   = pv;
                    next_link[pv]   = nx;
                    next_link[slot] = free_head;
                    free_head       = slot;
                    slot_used[slot] = 1'b0;
                    r.status        = STAT_OK;
                end
            end
            default: begin
                r.status = STAT_BAD_SLOT;
            end
        endcase
        return r;
    endfunction

    // compare one result beat with the oldest prediction
    function automatic void check_reply(logic [MDataW-1:0] beat);
        list_reply_t want;
        status_t got_status;
        slot_t   got_slot;
        got_status = status_t'(beat[StatusW-1:0]);
        got_slot   = beat[StatusW +: SlotW];
        if (expected_replies.size() == 0) begin
            $error("result beat with nothing pending: status %0d slot %0d",
                   got_status, got_slot);
            mismatches++;
        end else begin
            want = expected_replies.pop_front();
            replies_seen++;
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                mismatches++;
            end
            if (got_slot !== want.slot) begin
                $error("result_slot: expected %0d, got %0d", want.slot, got_slot);
                mismatches++;
            end
        end
    endfunction

    initial begin
        mismatches   = 0;
        replies_seen = 0;
        tally        = '{default: 0};
        clear_list();
    end

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        list_reply_t r;
        if (!aresetn) begin
            clear_list();
            expected_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_reply(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                r = apply_request(s_tuser, key_t'(s_tdata[KeyW-1:0]),
                                  s_tdata[KeyW +: SlotW]);
                tally[r.status]++;
                if (r.status == STAT_OK && s_tuser == ACT_SEARCH) begin
                    found_count <= found_count + 1;
                end
                expected_replies.push_back(r);
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_replies.size();
        reply_count   <= replies_seen;
        full_count    <= tally[STAT_FULL];
        missing_count <= tally[STAT_NOT_FOUND];
        bad_count     <= tally[STAT_BAD_SLOT];
    end

endmodule

[tb/sv/array_linked_list_with_free_list_tb.sv]
// testbench top: clock, reset, request and result traffic, verdict
module array_linked_list_with_free_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alfl_pkg::*;

    localparam int NodeCount     = NodeCountDef;
    localparam int ClkPeriod     = 20;
    localparam int IdleLimit     = 2000;
    localparam int HoldOffCycles = 300;
    localparam int PhaseCount    = 20;
    localparam int PhaseBeats    = 100;
    localparam int SettleCycles  = 40;

    // action code outside the enum, must come back as a bad slot
    localparam logic [ActionW-1:0] ActUnknown = 2'd3;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [SDataW-1:0] s_tdata;    // key_value[31:0], slot_index[35:32]
    logic [SUserW-1:0] s_tuser;    // action[1:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [MDataW-1:0] m_tdata;    // status[1:0], result_slot[5:2]

    int error_count;
    int pending_count;
    int reply_count;
    int full_count;
    int found_count;
    int missing_count;
    int bad_count;

    int   beats_sent;
    int   directed_beats;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   recv_stall_left;
    int   quiet_cycles;
    logic hold_off_req;
    logic hold_off_done;
    key_t key_pool[8];

    // keys used to fill the list in the directed part; index 10 repeats index 1
    key_t fill_keys[15] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0000_0000,
        32'sh0000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678,
        32'shFEDC_BA98, 32'sh0F0F_0F0F, 32'sh8000_0000, 32'shF0F0_F0F0,
        32'sh0000_FFFF, 32'shFFFF_0000, 32'sh7FFF_FFFE
    };

    array_linked_list_with_free_list #(
        .NODE_COUNT(NodeCount)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    array_linked_list_with_free_list_checker #(
        .NODE_COUNT(NodeCount)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .error_count  (error_count),
        .pending_count(pending_count),
        .reply_count  (reply_count),
        .full_count   (full_count),
        .found_count  (found_count),
        .missing_count(missing_count),
        .bad_count    (bad_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(ClkPeriod / 2) aclk = ~aclk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_span(int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // offer one request beat from a falling edge and return at the falling
    // edge after it is taken
    task automatic send_request(logic [ActionW-1:0] act, key_t key,
                                logic [SlotW-1:0] slot);
        logic [SDataW-1:0] payload;
        int gap;
        gap = idle_span(send_idle_pct);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        payload = '0;
        payload[KeyW-1:0]     = key;
        payload[KeyW +: SlotW] = slot;
        s_tdata  = payload;
        s_tuser  = act;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        @(negedge aclk);
    endtask

    // key for an insert or a search: often one seen before, so that
    // duplicates and hits are common
    task automatic pick_key(int reuse_pct, output key_t key);
        int r;
        r = $urandom_range(0, 99);
        if (r < reuse_pct) begin
            key = key_pool[$urandom_range(0, 7)];
        end else if (r < reuse_pct + (100 - reuse_pct) / 2) begin
            key = key_t'($urandom());
            key_pool[$urandom_range(0, 7)] = key;
        end else begin
            key = key_t'($urandom_range(0, 31)) - key_t'(16);
            key_pool[$urandom_range(0, 7)] = key;
        end
    endtask

    // one random request, weighted by the phase mode
    task automatic send_random(int insert_pct, int search_pct);
        int   r;
        key_t key;
        logic [SlotW-1:0] slot;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            send_request(ActUnknown, key_t'($urandom()), SlotW'($urandom_range(0, 15)));
        end else if (r < 2 + insert_pct) begin
            pick_key(40, key);
            send_request(ACT_INSERT, key, SlotW'($urandom_range(0, 15)));
        end else if (r < 2 + insert_pct + search_pct) begin
            pick_key(70, key);
            send_request(ACT_SEARCH, key, SlotW'($urandom_range(0, 15)));
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                slot = SlotW'($urandom_range(0, 15));
            end else begin
                slot = SlotW'($urandom_range(1, NodeCount - 1));
            end
            send_request(ACT_DELETE, key_t'($urandom()), slot);
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready        = 1'b0;
        recv_stall_left = 0;
        hold_off_done   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_tready = 1'b0;
                repeat (HoldOffCycles - 1) @(negedge aclk);
                hold_off_done = 1'b1;
            end else if (recv_stall_left > 0) begin
                m_tready = 1'b0;
                recv_stall_left--;
            end else begin
                m_tready = 1'b1;
                recv_stall_left = idle_span(recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < IdleLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus and verdict
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        hold_off_req   = 1'b0;
        beats_sent     = 0;
        send_idle_pct  = 30;
        recv_idle_pct  = 30;
        for (int i = 0; i < 8; i++) begin
            key_pool[i] = fill_keys[i];
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: empty list, rejected deletes and action, fill to full
        send_request(ACT_SEARCH, 32'sd5, 4'd0);
        send_request(ACT_DELETE, 32'sd0, 4'd0);
        send_request(ACT_DELETE, 32'sd0, 4'd5);
        send_request(ActUnknown, 32'shFFFF_FFFF, 4'd15);
        for (int i = 0; i < 15; i++) begin
            send_request(ACT_INSERT, fill_keys[i], 4'd0);
        end
        send_request(ACT_INSERT, 32'sh0BAD_0BAD, 4'd0);
        // duplicate key: the newer, head-side copy must win
        send_request(ACT_SEARCH, 32'sh8000_0000, 4'd0);
        // unlink at tail, head and middle, then a repeat delete
        send_request(ACT_DELETE, 32'sd0, 4'd1);
        send_request(ACT_DELETE, 32'sd0, 4'd15);
        send_request(ACT_DELETE, 32'sd0, 4'd8);
        send_request(ACT_DELETE, 32'sd0, 4'd8);
        send_request(ACT_SEARCH, fill_keys[7], 4'd0);
        directed_beats = beats_sent;

        // random phases: filling, draining and mixed traffic
        for (int p = 0; p < PhaseCount; p++) begin
            if (p % 5 == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(10, 60);
                recv_idle_pct = $urandom_range(10, 60);
            end
            for (int n = 0; n < PhaseBeats; n++) begin
                if (p == 4 && n == 10) begin
                    hold_off_req = 1'b1;
                end
                case (p % 3)
                    0:       send_random(65, 20);
                    1:       send_random(20, 20);
                    default: send_random(35, 35);
                endcase
            end
        end
        s_tvalid = 1'b0;

        // drain, then let the block settle
        recv_idle_pct = 20;
        while (pending_count != 0) @(negedge aclk);
        repeat (SettleCycles) @(posedge aclk);

        $display("summary: %0d request beats (%0d directed), %0d result beats checked",
                 beats_sent, directed_beats, reply_count);
        $display("summary: %0d inserts refused on a full list, %0d keys found,",
                 full_count, found_count);
        $display("summary: %0d searches missed, %0d bad slots or actions",
                 missing_count, bad_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
sv/alfl_pkg.sv
sv/alfl_store.sv
sv/alfl_ctrl.sv
sv/array_linked_list_with_free_list.sv
tb/sv/array_linked_list_with_free_list_checker.sv
tb/sv/array_linked_list_with_free_list_tb.sv
